@@ hdl/cksr_pkg.sv @@
// Shared codes and defaults for the credit key slot ring manager.
`timescale 1ns / 1ps
package cksr_pkg;

    // Parameter defaults
    localparam int SECTORS_DEF    = 256;
    localparam int REQUESTORS_DEF = 16;
    localparam int CREDIT_MAX_DEF = 15;

    // Request types
    localparam logic [1:0] REQ_REPORT = 2'd0;
    localparam logic [1:0] REQ_FINISH = 2'd1;
    localparam logic [1:0] REQ_ADD    = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    // Slot states
    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_VALID   = 2'd1;
    localparam logic [1:0] SLOT_CORRUPT = 2'd2;

    // Result status codes
    localparam logic [3:0] STS_OK          = 4'd0;
    localparam logic [3:0] STS_UNINIT      = 4'd1;
    localparam logic [3:0] STS_NO_STORAGE  = 4'd2;
    localparam logic [3:0] STS_CORRUPT     = 4'd3;
    localparam logic [3:0] STS_FULL        = 4'd4;
    localparam logic [3:0] STS_BAD_REQ     = 4'd5;
    localparam logic [3:0] STS_BAD_INDEX   = 4'd6;
    localparam logic [3:0] STS_EMPTY       = 4'd7;
    localparam logic [3:0] STS_NO_KEY      = 4'd8;
    localparam logic [3:0] STS_NO_CREDIT   = 4'd9;
    localparam logic [3:0] STS_READ_FAIL   = 4'd10;
    localparam logic [3:0] STS_WRITE_FAIL  = 4'd11;

    // Configuration register indexes
    localparam logic [1:0] CFG_SECTORS    = 2'd0;
    localparam logic [1:0] CFG_REQUESTORS = 2'd1;
    localparam logic [1:0] CFG_CREDIT     = 2'd2;

    // Configuration reset values
    localparam logic [8:0] CFG_SECTORS_RST    = 9'd256;
    localparam logic [4:0] CFG_REQUESTORS_RST = 5'd4;
    localparam logic [3:0] CFG_CREDIT_RST     = 4'd4;

endpackage

@@ hdl/cksr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cksr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/credit_key_slot_ring_manager.sv @@
// Top level: slot table sequencer with ring indices and per-requestor credits.
//
// Usage:
//  Input channel (in_valid/in_ready) carries one request: a sector report, a
//  finish scan, an add key or a remove key. Every request produces exactly one
//  result on the output channel (out_valid/out_ready) with status, sector and
//  ring flags. One request is in work at a time; the next is taken as soon as
//  the result sits in the output register, even if it is not yet taken.
//  Finish walks the slot table through the single slot RAM: a three-way
//  partition over the table, then a pass that hands out owners and credits
//  over the ring slots. The slot RAM has one read and one write per cycle
//  and registered read data.
//  After reset the slot RAM is cleared one entry per cycle, all SECTORS entries,
//  with in_ready low; configuration writes are taken during that pass.
//  A stalled receiver holds the result; the next request is then held at the
//  end of its work until the output register frees.
//  Configuration: cfg_we with cfg_index and cfg_data, no wait, no read-back.
`timescale 1ns / 1ps
module credit_key_slot_ring_manager
    import cksr_pkg::*;
#(
    parameter int SECTORS    = SECTORS_DEF,
    parameter int REQUESTORS = REQUESTORS_DEF,
    parameter int CREDIT_MAX = CREDIT_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [3:0] requestor,
    input  logic       data_found,
    input  logic       erase_ok,
    input  logic       write_ok,
    input  logic       read_ok,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] status,
    output logic [7:0] sector,
    output logic       queue_full,
    output logic       queue_empty,
    output logic       ready_res,
    output logic       storage_fault
);

    localparam int IW   = $clog2(SECTORS);
    localparam int IXW  = $clog2(SECTORS + 1);
    localparam int SW   = IW;
    localparam int OW   = $clog2(REQUESTORS + 1);
    localparam int RW   = (REQUESTORS > 1) ? $clog2(REQUESTORS) : 1;
    localparam int CRW  = $clog2(CREDIT_MAX + 1);
    localparam int NKW  = $clog2(REQUESTORS * CREDIT_MAX + 2);
    localparam int CW0  = (NKW > IXW) ? NKW : IXW;
    localparam int CW   = (CW0 > 9) ? CW0 : 9;
    localparam int EW   = 2 + SW + OW;
    localparam logic [OW-1:0] UNASSIGNED = OW'(REQUESTORS);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_REP_W,
        S_F_MID, S_F_MIDD, S_F_OTHD, S_F_SW2, S_F_END, S_F_ORD, S_F_OWR,
        S_ADD_D, S_REM_D, S_MAP, S_MAP_D, S_MAP_W2, S_TK, S_TK_PD, S_TK_W,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]     cfg_ns_reg;
    logic [4:0]     cfg_rc_reg;
    logic [3:0]     cfg_cl_reg;

    logic [1:0]     op_type_reg, op_type_next;
    logic [3:0]     op_req_reg, op_req_next;
    logic           op_found_reg, op_found_next;
    logic           op_erase_reg, op_erase_next;
    logic           op_write_reg, op_write_next;
    logic           op_read_reg, op_read_next;

    logic [IXW-1:0] add_idx_reg, add_idx_next;
    logic [IXW-1:0] take_idx_reg, take_idx_next;
    logic [IXW-1:0] spare_idx_reg, spare_idx_next;
    logic [IXW-1:0] scan_cnt_reg, scan_cnt_next;
    logic           cache_ready_reg, cache_ready_next;
    logic           fault_reg, fault_next;
    logic [CRW-1:0] credit_reg [REQUESTORS];
    logic [CRW-1:0] credit_next [REQUESTORS];

    logic [IXW-1:0] lo_reg, lo_next;
    logic [IXW-1:0] mid_reg, mid_next;
    logic [IXW-1:0] hi_reg, hi_next;
    logic [IXW-1:0] oth_addr_reg, oth_addr_next;
    logic [IXW-1:0] i_cnt_reg, i_cnt_next;
    logic [RW-1:0]  r_cnt_reg, r_cnt_next;
    logic [IW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [EW-1:0]  cur_ent_reg, cur_ent_next;
    logic [IXW-1:0] cur_addr_reg, cur_addr_next;
    logic [EW-1:0]  hold_ent_reg, hold_ent_next;

    logic [3:0]     res_status_reg, res_status_next;
    logic [7:0]     res_sector_reg, res_sector_next;

    logic           out_valid_reg, out_valid_next;
    logic [3:0]     out_status_reg, out_status_next;
    logic [7:0]     out_sector_reg, out_sector_next;
    logic           out_full_reg, out_full_next;
    logic           out_empty_reg, out_empty_next;
    logic           out_rdy_reg, out_rdy_next;
    logic           out_fault_reg, out_fault_next;

    // Slot RAM port
    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    logic [EW-1:0]  ram_wdata;
    logic [IW-1:0]  ram_raddr;
    logic [EW-1:0]  ram_rdata;

    // Effective configuration
    logic [CW-1:0]  ns_w, rc_w, cl_w, nk_w;
    logic [CW-1:0]  add_nx_w, take_nx_w, prev_w;

    logic [1:0]     rd_status, cur_status, hold_status;
    logic [SW-1:0]  rd_sector, cur_sector;
    logic [OW-1:0]  rd_owner, cur_owner;
    logic [RW-1:0]  req_idx;

    assign rd_status   = ram_rdata[1:0];
    assign rd_sector   = ram_rdata[SW+1:2];
    assign rd_owner    = ram_rdata[EW-1:SW+2];
    assign cur_status  = cur_ent_reg[1:0];
    assign cur_sector  = cur_ent_reg[SW+1:2];
    assign cur_owner   = cur_ent_reg[EW-1:SW+2];
    assign hold_status = hold_ent_reg[1:0];
    assign req_idx     = RW'(op_req_reg);

    always_comb
    begin
        ns_w = (CW'(cfg_ns_reg) > CW'(SECTORS)) ? CW'(SECTORS) : CW'(cfg_ns_reg);
        if (cfg_rc_reg == 5'd0)
            rc_w = CW'(1);
        else if (CW'(cfg_rc_reg) > CW'(REQUESTORS))
            rc_w = CW'(REQUESTORS);
        else
            rc_w = CW'(cfg_rc_reg);
        if (cfg_cl_reg == 4'd0)
            cl_w = CW'(1);
        else if (CW'(cfg_cl_reg) > CW'(CREDIT_MAX))
            cl_w = CW'(CREDIT_MAX);
        else
            cl_w = CW'(cfg_cl_reg);
        nk_w      = rc_w * cl_w + CW'(1);
        add_nx_w  = (CW'(add_idx_reg) + CW'(1) == nk_w) ? '0 : CW'(add_idx_reg) + CW'(1);
        take_nx_w = (CW'(take_idx_reg) + CW'(1) == nk_w) ? '0 : CW'(take_idx_reg) + CW'(1);
        prev_w    = (take_idx_reg == '0) ? nk_w - CW'(1) : CW'(take_idx_reg) - CW'(1);
    end

    cksr_ram #(
        .WIDTH (EW),
        .DEPTH (SECTORS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        op_type_next     = op_type_reg;
        op_req_next      = op_req_reg;
        op_found_next    = op_found_reg;
        op_erase_next    = op_erase_reg;
        op_write_next    = op_write_reg;
        op_read_next     = op_read_reg;
        add_idx_next     = add_idx_reg;
        take_idx_next    = take_idx_reg;
        spare_idx_next   = spare_idx_reg;
        scan_cnt_next    = scan_cnt_reg;
        cache_ready_next = cache_ready_reg;
        fault_next       = fault_reg;
        credit_next      = credit_reg;
        lo_next          = lo_reg;
        mid_next         = mid_reg;
        hi_next          = hi_reg;
        oth_addr_next    = oth_addr_reg;
        i_cnt_next       = i_cnt_reg;
        r_cnt_next       = r_cnt_reg;
        clr_cnt_next     = clr_cnt_reg;
        cur_ent_next     = cur_ent_reg;
        cur_addr_next    = cur_addr_reg;
        hold_ent_next    = hold_ent_reg;
        res_status_next  = res_status_reg;
        res_sector_next  = res_sector_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_sector_next  = out_sector_reg;
        out_full_next    = out_full_reg;
        out_empty_next   = out_empty_reg;
        out_rdy_next     = out_rdy_reg;
        out_fault_next   = out_fault_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + IW'(1);
                if (IXW'(clr_cnt_reg) == IXW'(SECTORS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_type_next  = req_type;
                    op_req_next   = requestor;
                    op_found_next = data_found;
                    op_erase_next = erase_ok;
                    op_write_next = write_ok;
                    op_read_next  = read_ok;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                res_status_next = STS_OK;
                res_sector_next = '0;
                state_next      = S_RESP;
                unique case (op_type_reg)
                    REQ_REPORT:
                    begin
                        if (CW'(scan_cnt_reg) < CW'(SECTORS))
                        begin
                            ram_raddr  = IW'(scan_cnt_reg);
                            state_next = S_REP_W;
                        end
                    end
                    REQ_FINISH:
                    begin
                        if (ns_w == '0)
                            res_status_next = STS_NO_STORAGE;
                        else
                        begin
                            lo_next    = '0;
                            mid_next   = '0;
                            hi_next    = IXW'(ns_w - CW'(1));
                            state_next = S_F_MID;
                        end
                    end
                    REQ_ADD:
                    begin
                        if (!cache_ready_reg)
                            res_status_next = STS_UNINIT;
                        else if (fault_reg)
                            res_status_next = STS_NO_STORAGE;
                        else if (CW'(add_idx_reg) >= nk_w || CW'(add_idx_reg) >= ns_w)
                        begin
                            cache_ready_next = 1'b0;
                            res_status_next  = STS_CORRUPT;
                        end
                        else
                        begin
                            ram_raddr  = IW'(add_idx_reg);
                            state_next = S_ADD_D;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!cache_ready_reg)
                            res_status_next = STS_UNINIT;
                        else if (fault_reg)
                            res_status_next = STS_NO_STORAGE;
                        else if (CW'(op_req_reg) >= rc_w)
                            res_status_next = STS_BAD_REQ;
                        else if (CW'(take_idx_reg) >= nk_w || CW'(take_idx_reg) >= ns_w)
                        begin
                            cache_ready_next = 1'b0;
                            res_status_next  = STS_BAD_INDEX;
                        end
                        else if (add_idx_reg == take_idx_reg)
                            res_status_next = STS_EMPTY;
                        else
                        begin
                            ram_raddr  = IW'(take_idx_reg);
                            state_next = S_REM_D;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_REP_W:
            begin
                ram_we    = 1'b1;
                ram_waddr = IW'(scan_cnt_reg);
                ram_wdata = {rd_owner, SW'(scan_cnt_reg),
                             op_found_reg ? SLOT_VALID :
                             (op_erase_reg ? SLOT_EMPTY : SLOT_CORRUPT)};
                scan_cnt_next = scan_cnt_reg + IXW'(1);
                state_next    = S_RESP;
            end
            // Three-way partition: valid low, empty middle, corrupted high
            S_F_MID:
            begin
                if (mid_reg < hi_reg)
                begin
                    ram_raddr  = IW'(mid_reg);
                    state_next = S_F_MIDD;
                end
                else
                    state_next = S_F_END;
            end
            S_F_MIDD:
            begin
                hold_ent_next = ram_rdata;
                case (rd_status)
                    SLOT_VALID:
                    begin
                        ram_raddr     = IW'(lo_reg);
                        oth_addr_next = lo_reg;
                        state_next    = S_F_OTHD;
                    end
                    SLOT_EMPTY:
                    begin
                        mid_next   = mid_reg + IXW'(1);
                        state_next = S_F_MID;
                    end
                    default:
                    begin
                        ram_raddr     = IW'(hi_reg);
                        oth_addr_next = hi_reg;
                        state_next    = S_F_OTHD;
                    end
                endcase
            end
            S_F_OTHD:
            begin
                state_next = S_F_MID;
                if (rd_status != hold_status)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = IW'(mid_reg);
                    ram_wdata    = ram_rdata;
                    state_next   = S_F_SW2;
                end
                if (hold_status == SLOT_VALID)
                begin
                    lo_next  = lo_reg + IXW'(1);
                    mid_next = mid_reg + IXW'(1);
                end
                else if (hi_reg != '0)
                    hi_next = hi_reg - IXW'(1);
            end
            S_F_SW2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = IW'(oth_addr_reg);
                ram_wdata  = hold_ent_reg;
                state_next = S_F_MID;
            end
            S_F_END:
            begin
                take_idx_next = '0;
                add_idx_next  = (CW'(lo_reg) >= nk_w) ? IXW'(nk_w - CW'(1)) : lo_reg;
                if (CW'(hi_reg) + CW'(1) < nk_w)
                    fault_next = 1'b1;
                spare_idx_next = hi_reg;
                i_cnt_next     = '0;
                r_cnt_next     = '0;
                state_next     = S_F_ORD;
            end
            // Hand out owners and credits over the ring
            S_F_ORD:
            begin
                if (CW'(i_cnt_reg) < nk_w && CW'(i_cnt_reg) < CW'(SECTORS))
                begin
                    ram_raddr  = IW'(i_cnt_reg);
                    state_next = S_F_OWR;
                end
                else
                begin
                    cache_ready_next = 1'b1;
                    scan_cnt_next    = '0;
                    res_status_next  = STS_OK;
                    state_next       = S_RESP;
                end
            end
            S_F_OWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = IW'(i_cnt_reg);
                if (rd_status == SLOT_VALID && CW'(credit_reg[r_cnt_reg]) < cl_w)
                begin
                    credit_next[r_cnt_reg] = credit_reg[r_cnt_reg] + CRW'(1);
                    ram_wdata = {UNASSIGNED, rd_sector, rd_status};
                end
                else
                    ram_wdata = {OW'(r_cnt_reg), rd_sector, rd_status};
                i_cnt_next = i_cnt_reg + IXW'(1);
                r_cnt_next = (CW'(r_cnt_reg) + CW'(1) == rc_w) ? '0 : r_cnt_reg + RW'(1);
                state_next = S_F_ORD;
            end
            S_ADD_D:
            begin
                cur_ent_next  = ram_rdata;
                cur_addr_next = add_idx_reg;
                state_next    = S_RESP;
                if (CW'(rd_owner) >= rc_w || CW'(rd_sector) >= ns_w)
                begin
                    cache_ready_next = 1'b0;
                    res_status_next  = STS_CORRUPT;
                end
                else if (add_nx_w == CW'(take_idx_reg))
                    res_status_next = STS_FULL;
                else
                begin
                    res_sector_next = 8'(rd_sector);
                    if (!op_write_reg)
                    begin
                        res_status_next = STS_WRITE_FAIL;
                        state_next      = S_MAP;
                    end
                    else
                    begin
                        if (CW'(credit_reg[RW'(rd_owner)]) < cl_w)
                            credit_next[RW'(rd_owner)] = credit_reg[RW'(rd_owner)] + CRW'(1);
                        ram_we       = 1'b1;
                        ram_waddr    = IW'(add_idx_reg);
                        ram_wdata    = {UNASSIGNED, rd_sector, SLOT_VALID};
                        add_idx_next = IXW'(add_nx_w);
                    end
                end
            end
            S_REM_D:
            begin
                cur_ent_next  = ram_rdata;
                cur_addr_next = take_idx_reg;
                if (rd_status != SLOT_VALID)
                begin
                    res_status_next = STS_NO_KEY;
                    state_next      = S_TK;
                end
                else if (CW'(rd_sector) >= ns_w)
                begin
                    cache_ready_next = 1'b0;
                    res_status_next  = STS_CORRUPT;
                    state_next       = S_RESP;
                end
                else if (credit_reg[req_idx] == '0)
                begin
                    res_status_next = STS_NO_CREDIT;
                    state_next      = S_RESP;
                end
                else
                begin
                    res_sector_next = 8'(rd_sector);
                    res_status_next = op_read_reg ? STS_OK : STS_READ_FAIL;
                    state_next      = op_erase_reg ? S_TK : S_MAP;
                end
            end
            // Remap the current slot onto the top spare sector
            S_MAP:
            begin
                if (CW'(spare_idx_reg) <= nk_w || CW'(spare_idx_reg) >= CW'(SECTORS))
                begin
                    cache_ready_next = 1'b0;
                    state_next = (op_type_reg == REQ_ADD) ? S_RESP : S_TK;
                end
                else
                begin
                    ram_raddr  = IW'(spare_idx_reg);
                    state_next = S_MAP_D;
                end
            end
            S_MAP_D:
            begin
                cur_ent_next  = {cur_owner, rd_sector, cur_status};
                ram_we        = 1'b1;
                ram_waddr     = IW'(cur_addr_reg);
                ram_wdata     = {cur_owner, rd_sector, cur_status};
                hold_ent_next = {ram_rdata[EW-1:SW+2], cur_sector, rd_status};
                state_next    = S_MAP_W2;
            end
            S_MAP_W2:
            begin
                ram_we         = 1'b1;
                ram_waddr      = IW'(spare_idx_reg);
                ram_wdata      = hold_ent_reg;
                spare_idx_next = spare_idx_reg - IXW'(1);
                state_next     = (op_type_reg == REQ_ADD) ? S_RESP : S_TK;
            end
            // Advance the take index
            S_TK:
            begin
                if (credit_reg[req_idx] != '0)
                    credit_next[req_idx] = credit_reg[req_idx] - CRW'(1);
                if (prev_w < CW'(SECTORS))
                begin
                    ram_raddr  = IW'(prev_w);
                    state_next = S_TK_PD;
                end
                else
                    state_next = S_TK_W;
            end
            S_TK_PD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = IW'(prev_w);
                ram_wdata  = {OW'(op_req_reg), rd_sector, rd_status};
                state_next = S_TK_W;
            end
            S_TK_W:
            begin
                ram_we        = 1'b1;
                ram_waddr     = IW'(cur_addr_reg);
                ram_wdata     = {UNASSIGNED, cur_sector, SLOT_EMPTY};
                take_idx_next = IXW'(take_nx_w);
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_sector_next = res_sector_reg;
                    out_full_next   = (CW'(add_idx_reg) < nk_w) &&
                                      (add_nx_w == CW'(take_idx_reg));
                    out_empty_next  = (add_idx_reg == take_idx_reg);
                    out_rdy_next    = cache_ready_reg;
                    out_fault_next  = fault_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            cfg_ns_reg      <= CFG_SECTORS_RST;
            cfg_rc_reg      <= CFG_REQUESTORS_RST;
            cfg_cl_reg      <= CFG_CREDIT_RST;
            add_idx_reg     <= '0;
            take_idx_reg    <= '0;
            spare_idx_reg   <= '0;
            scan_cnt_reg    <= '0;
            cache_ready_reg <= 1'b0;
            fault_reg       <= 1'b0;
            for (int k = 0; k < REQUESTORS; k++)
            begin
                credit_reg[k] <= '0;
            end
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= STS_OK;
            out_sector_reg  <= '0;
            out_full_reg    <= 1'b0;
            out_empty_reg   <= 1'b0;
            out_rdy_reg     <= 1'b0;
            out_fault_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SECTORS:    cfg_ns_reg <= cfg_data;
                    CFG_REQUESTORS: cfg_rc_reg <= cfg_data[4:0];
                    CFG_CREDIT:     cfg_cl_reg <= cfg_data[3:0];
                    default:        cfg_ns_reg <= cfg_ns_reg;
                endcase
            end
            add_idx_reg     <= add_idx_next;
            take_idx_reg    <= take_idx_next;
            spare_idx_reg   <= spare_idx_next;
            scan_cnt_reg    <= scan_cnt_next;
            cache_ready_reg <= cache_ready_next;
            fault_reg       <= fault_next;
            credit_reg      <= credit_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_sector_reg  <= out_sector_next;
            out_full_reg    <= out_full_next;
            out_empty_reg   <= out_empty_next;
            out_rdy_reg     <= out_rdy_next;
            out_fault_reg   <= out_fault_next;
        end
    end

    // Work registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_type_reg     <= op_type_next;
        op_req_reg      <= op_req_next;
        op_found_reg    <= op_found_next;
        op_erase_reg    <= op_erase_next;
        op_write_reg    <= op_write_next;
        op_read_reg     <= op_read_next;
        lo_reg          <= lo_next;
        mid_reg         <= mid_next;
        hi_reg          <= hi_next;
        oth_addr_reg    <= oth_addr_next;
        i_cnt_reg       <= i_cnt_next;
        r_cnt_reg       <= r_cnt_next;
        cur_ent_reg     <= cur_ent_next;
        cur_addr_reg    <= cur_addr_next;
        hold_ent_reg    <= hold_ent_next;
        res_status_reg  <= res_status_next;
        res_sector_reg  <= res_sector_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign sector        = out_sector_reg;
    assign queue_full    = out_full_reg;
    assign queue_empty   = out_empty_reg;
    assign ready_res     = out_rdy_reg;
    assign storage_fault = out_fault_reg;

endmodule

@@ hdl/cksr_checker.sv @@
// Port-level checks for the credit key slot ring manager, bound to the top level.
`timescale 1ns / 1ps
module cksr_props
    import cksr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_we,
    input logic [1:0] cfg_index,
    input logic [8:0] cfg_data,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] req_type,
    input logic [3:0] requestor,
    input logic       data_found,
    input logic       erase_ok,
    input logic       write_ok,
    input logic       read_ok,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] status,
    input logic [7:0] sector,
    input logic       queue_full,
    input logic       queue_empty,
    input logic       ready_res,
    input logic       storage_fault
);

    // Storage fault is sticky until reset
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        storage_fault |=> storage_fault)
        else $error("storage fault dropped");

    // A ring of two or more slots cannot be full and empty at once
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(queue_full && queue_empty))
        else $error("ring full and empty together");

    // Index corruption drops the ready flag
    a_corrupt_unready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STS_CORRUPT || status == STS_BAD_INDEX)) |-> !ready_res)
        else $error("corruption reported while ready");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(sector)))
        else $error("stalled result changed");

endmodule

bind credit_key_slot_ring_manager cksr_props u_cksr_props (.*);

@@ tb/cksr_checker.sv @@
// Checker: watches the request and result channels, predicts results, compares.
`timescale 1ns / 1ps
module cksr_checker
    import cksr_pkg::*;
#(
    parameter int SECTORS    = SECTORS_DEF,
    parameter int REQUESTORS = REQUESTORS_DEF,
    parameter int CREDIT_MAX = CREDIT_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [3:0] requestor,
    input  logic       data_found,
    input  logic       erase_ok,
    input  logic       write_ok,
    input  logic       read_ok,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [3:0] status,
    input  logic [7:0] sector,
    input  logic       queue_full,
    input  logic       queue_empty,
    input  logic       ready_res,
    input  logic       storage_fault,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] sector;
        logic       full;
        logic       empty;
        logic       rdy;
        logic       fault;
    } result_t;

    result_t expected_results[$];

    logic [1:0] slot_st [SECTORS];
    int         slot_sec [SECTORS];
    int         slot_own [SECTORS];
    int         credit_cnt [REQUESTORS];
    int         add_ptr, take_ptr, spare_ptr, scan_ptr;
    bit         cache_ok, fault;
    int         sectors_reg, reqs_reg, credit_reg;

    assign pending = expected_results.size();

    function automatic int eff_sectors();
        return sectors_reg > SECTORS ? SECTORS : sectors_reg;
    endfunction

    function automatic int eff_reqs();
        if (reqs_reg < 1) return 1;
        return reqs_reg > REQUESTORS ? REQUESTORS : reqs_reg;
    endfunction

    function automatic int eff_credit();
        if (credit_reg < 1) return 1;
        return credit_reg > CREDIT_MAX ? CREDIT_MAX : credit_reg;
    endfunction

    function automatic int ring_len();
        return eff_reqs() * eff_credit() + 1;
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [1:0] s;
        int p, o;
        s = slot_st[a]; p = slot_sec[a]; o = slot_own[a];
        slot_st[a] = slot_st[b]; slot_sec[a] = slot_sec[b]; slot_own[a] = slot_own[b];
        slot_st[b] = s; slot_sec[b] = p; slot_own[b] = o;
    endfunction

    function automatic void remap_to_spare(int logical);
        int t;
        if (spare_ptr <= ring_len() || spare_ptr >= SECTORS || logical >= SECTORS) begin
            cache_ok = 0;
            return;
        end
        t = slot_sec[logical];
        slot_sec[logical] = slot_sec[spare_ptr];
        slot_sec[spare_ptr] = t;
        spare_ptr = spare_ptr - 1;
    endfunction

    function automatic void step_take(int req, int nk);
        int prv;
        prv = (take_ptr == 0) ? nk - 1 : take_ptr - 1;
        if (credit_cnt[req] > 0) credit_cnt[req]--;
        if (prv < SECTORS) slot_own[prv] = req;
        slot_own[take_ptr] = REQUESTORS;
        slot_st[take_ptr] = SLOT_EMPTY;
        take_ptr = (take_ptr + 1) % nk;
    endfunction

    function automatic logic [3:0] partition_table();
        int ns, nk, rc, cl, lo, mid, hi, r;
        ns = eff_sectors(); nk = ring_len(); rc = eff_reqs(); cl = eff_credit();
        lo = 0; mid = 0; r = 0;
        if (ns == 0) return STS_NO_STORAGE;
        hi = ns - 1;
        while (mid < hi) begin
            if (slot_st[mid] == SLOT_VALID) begin
                if (slot_st[lo] != SLOT_VALID) swap_entries(lo, mid);
                lo++; mid++;
            end else if (slot_st[mid] == SLOT_EMPTY) begin
                mid++;
            end else begin
                if (slot_st[mid] != slot_st[hi]) swap_entries(mid, hi);
                if (hi > 0) hi--;
            end
        end
        take_ptr = 0;
        add_ptr = (lo >= nk) ? nk - 1 : lo;
        if (hi + 1 < nk) fault = 1;
        spare_ptr = hi;
        for (int i = 0; i < nk && i < SECTORS; i++) begin
            slot_own[i] = r;
            if (slot_st[i] == SLOT_VALID && credit_cnt[r] < cl) begin
                credit_cnt[r]++;
                slot_own[i] = REQUESTORS;
            end
            r = (r + 1) % rc;
        end
        cache_ok = 1;
        scan_ptr = 0;
        return STS_OK;
    endfunction

    function automatic logic [3:0] add_key(bit wok, ref int sec);
        int ns, nk, ai, own;
        ns = eff_sectors(); nk = ring_len(); ai = add_ptr;
        if (!cache_ok) return STS_UNINIT;
        if (fault) return STS_NO_STORAGE;
        if (ai >= nk || ai >= ns) begin cache_ok = 0; return STS_CORRUPT; end
        own = slot_own[ai];
        if (own >= eff_reqs()) begin cache_ok = 0; return STS_CORRUPT; end
        if (slot_sec[ai] >= ns) begin cache_ok = 0; return STS_CORRUPT; end
        if ((ai + 1) % nk == take_ptr) return STS_FULL;
        sec = slot_sec[ai];
        if (!wok) begin remap_to_spare(ai); return STS_WRITE_FAIL; end
        if (credit_cnt[own] < eff_credit()) credit_cnt[own]++;
        slot_own[ai] = REQUESTORS;
        slot_st[ai] = SLOT_VALID;
        add_ptr = (ai + 1) % nk;
        return STS_OK;
    endfunction

    function automatic logic [3:0] remove_key(int req, bit rok, bit eok, ref int sec);
        int ns, nk, ti;
        ns = eff_sectors(); nk = ring_len(); ti = take_ptr;
        if (!cache_ok) return STS_UNINIT;
        if (fault) return STS_NO_STORAGE;
        if (req >= eff_reqs()) return STS_BAD_REQ;
        if (ti >= nk || ti >= ns) begin cache_ok = 0; return STS_BAD_INDEX; end
        if (add_ptr == ti) return STS_EMPTY;
        if (slot_st[ti] != SLOT_VALID) begin step_take(req, nk); return STS_NO_KEY; end
        if (slot_sec[ti] >= ns) begin cache_ok = 0; return STS_CORRUPT; end
        if (credit_cnt[req] == 0) return STS_NO_CREDIT;
        sec = slot_sec[ti];
        if (!eok) remap_to_spare(ti);
        step_take(req, nk);
        return rok ? STS_OK : STS_READ_FAIL;
    endfunction

    function automatic result_t predict_result(logic [1:0] kind, int req, bit found,
                                               bit eok, bit wok, bit rok);
        result_t res;
        int sec, nk;
        sec = 0;
        res.status = STS_OK;
        case (kind)
            REQ_REPORT: begin
                if (scan_ptr < SECTORS) begin
                    slot_st[scan_ptr] = found ? SLOT_VALID : (eok ? SLOT_EMPTY : SLOT_CORRUPT);
                    slot_sec[scan_ptr] = scan_ptr;
                    scan_ptr++;
                end
            end
            REQ_FINISH: res.status = partition_table();
            REQ_ADD:    res.status = add_key(wok, sec);
            default:    res.status = remove_key(req, rok, eok, sec);
        endcase
        nk = ring_len();
        res.sector = sec[7:0];
        res.full   = (add_ptr < nk && (add_ptr + 1) % nk == take_ptr);
        res.empty  = (add_ptr == take_ptr);
        res.rdy    = cache_ok;
        res.fault  = fault;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t got, want;
        if (!rst_n) begin
            for (int i = 0; i < SECTORS; i++) begin
                slot_st[i] = SLOT_EMPTY; slot_sec[i] = 0; slot_own[i] = 0;
            end
            for (int i = 0; i < REQUESTORS; i++) credit_cnt[i] = 0;
            add_ptr = 0; take_ptr = 0; spare_ptr = 0; scan_ptr = 0;
            cache_ok = 0; fault = 0;
            sectors_reg = CFG_SECTORS_RST;
            reqs_reg = CFG_REQUESTORS_RST;
            credit_reg = CFG_CREDIT_RST;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SECTORS:    sectors_reg = cfg_data;
                    CFG_REQUESTORS: reqs_reg = cfg_data[4:0];
                    CFG_CREDIT:     credit_reg = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_result(req_type, requestor, data_found,
                                                          erase_ok, write_ok, read_ok));
            if (out_valid && out_ready) begin
                got = '{status, sector, queue_full, queue_empty, ready_res, storage_fault};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb;
    import cksr_pkg::*;

    logic       clk = 0, rst_n = 0;
    logic       cfg_we = 0;
    logic [1:0] cfg_index = CFG_SECTORS;
    logic [8:0] cfg_data = '0;
    logic       in_valid = 0, in_ready;
    logic [1:0] req_type = REQ_REPORT;
    logic [3:0] requestor = '0;
    logic       data_found = 0, erase_ok = 0, write_ok = 0, read_ok = 0;
    logic       out_valid, out_ready = 0;
    logic [3:0] status;
    logic [7:0] sector;
    logic       queue_full, queue_empty, ready_res, storage_fault;
    int         fail_count, pending;
    bit         calm = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    credit_key_slot_ring_manager dut (.*);
    cksr_checker chk (.*);

    // Receiver: random stall bursts, none once the run goes calm.
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 7);
                out_ready <= 0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= value[8:0];
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Valid stays high into the next request unless an idle burst is drawn.
    task automatic send_req(logic [1:0] kind, int req, bit found, bit eok, bit wok, bit rok);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1; req_type <= kind; requestor <= req[3:0];
        data_found <= found; erase_ok <= eok; write_ok <= wok; read_ok <= rok;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random();
        send_req(2'($urandom_range(0, 3)), $urandom_range(0, 15),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Report a sector table with bad_pct percent of sectors drawn bad, then finish the scan.
    task automatic scan_table(int count, int bad_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < bad_pct)
                send_req(REQ_REPORT, 0, 0, 1'($urandom_range(0, 1)), 0, 0);
            else
                send_req(REQ_REPORT, 0, $urandom_range(0, 3) != 0, 1, 0, 0);
        end
        send_req(REQ_FINISH, 0, 0, 0, 0, 0);
    endtask

    // Mostly well-formed add/remove traffic with occasional failures.
    task automatic ring_traffic(int count, int rc);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_random();
            else if ($urandom_range(0, 1) != 0)
                send_req(REQ_ADD, 0, 0, 0, $urandom_range(0, 7) != 0, 0);
            else
                send_req(REQ_REMOVE, $urandom_range(0, rc > 0 ? rc - 1 : 0), 0,
                         $urandom_range(0, 7) != 0, 0, $urandom_range(0, 7) != 0);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        do @(posedge clk); while (pending != 0);
        repeat (400) @(posedge clk);
    endtask

    task automatic set_config(int ns, int rc, int cl);
        write_reg(CFG_SECTORS, ns);
        write_reg(CFG_REQUESTORS, rc);
        write_reg(CFG_CREDIT, cl);
    endtask

    initial
    begin
        int rc;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        // Directed: requests before init, then small table and extremes.
        set_config(8, 1, 1);
        send_req(REQ_ADD, 0, 0, 0, 1, 0);
        send_req(REQ_REMOVE, 15, 0, 1, 0, 1);
        send_req(REQ_REPORT, 0, 1, 1, 0, 0);
        send_req(REQ_REPORT, 0, 0, 1, 0, 0);
        send_req(REQ_REPORT, 0, 0, 0, 0, 0);
        send_req(REQ_REPORT, 0, 1, 0, 0, 0);
        send_req(REQ_REPORT, 0, 1, 1, 0, 0);
        send_req(REQ_FINISH, 0, 0, 0, 0, 0);
        send_req(REQ_REMOVE, 15, 0, 1, 0, 1);
        send_req(REQ_ADD, 0, 0, 0, 0, 0);
        send_req(REQ_ADD, 0, 0, 0, 1, 1);
        send_req(REQ_ADD, 0, 0, 0, 1, 1);
        send_req(REQ_REMOVE, 0, 0, 0, 0, 0);
        send_req(REQ_REMOVE, 0, 0, 1, 0, 1);
        send_req(REQ_REMOVE, 0, 1, 1, 1, 1);
        drain();
        set_config(0, 0, 0);
        send_req(REQ_FINISH, 0, 0, 0, 0, 0);
        send_req(REQ_ADD, 0, 0, 0, 1, 0);
        drain();
        // Random phases over several settings, small tables mostly.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin rc = 16; set_config(256, 16, 15); end
                1: begin rc = 2;  set_config(20, 2, 3); end
                7: begin rc = 3;  set_config(511, 31, 15); calm = 1; end
                default:
                begin
                    rc = $urandom_range(1, 6);
                    set_config($urandom_range(2, 60), rc, $urandom_range(1, 6));
                end
            endcase
            scan_table((ph == 0 || ph == 7) ? 40 : $urandom_range(10, 40),
                       (ph == 4) ? 60 : 10);
            ring_traffic(60, rc > 16 ? 16 : rc);
            for (int k = 0; k < 5; k++) send_random();
            drain();
        end
        // Loose noise last.
        for (int k = 0; k < 40; k++) send_random();
        drain();
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

endmodule

@@ credit_key_slot_ring_manager.f @@
hdl/cksr_pkg.sv
hdl/cksr_ram.sv
hdl/credit_key_slot_ring_manager.sv
hdl/cksr_checker.sv
tb/cksr_checker.sv
tb/tb.sv
